// ===== design/rbra_pkg.sv =====
// Shared constants and types for the register bank read arbiter.
// No dependencies; imported by every module of the block.
package rbra_pkg;

    localparam int COLLECTOR_ROWS = 4;   // 1 to 4
    localparam int BANKS          = 4;   // 2 to 4
    localparam int SRC_COLS       = 3;
    localparam int SLOT_COUNT     = COLLECTOR_ROWS * SRC_COLS;
    localparam int SLOT_MAX       = 12;

    localparam int BANK_W         = 2;
    localparam int BANK_PTR_DEPTH = 2 ** BANK_W;
    localparam int PTR_W          = 4;
    localparam int ADDR_W         = 8;
    localparam int ROW_W          = 2;
    localparam int COL_W          = 2;

    localparam int S_TDATA_W      = 136;
    localparam int M_TDATA_W      = 24;

    // What one row lane reports once the grant is known.
    typedef struct packed {
        logic              hit;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
    } lane_res_t;

endpackage

// ===== design/rbra_lane.sv =====
// One collector row: bank match for its three source slots and readout
// of the granted slot. Depends on rbra_pkg.
module rbra_lane (
    input  logic [rbra_pkg::SRC_COLS-1:0]            slot_valid,
    input  logic [rbra_pkg::SRC_COLS*2-1:0]          slot_banks,
    input  logic [rbra_pkg::SRC_COLS*rbra_pkg::ADDR_W-1:0] slot_addr,
    input  logic [rbra_pkg::BANK_W-1:0]              bank_select,
    input  logic [rbra_pkg::SRC_COLS-1:0]            grant,
    output logic [rbra_pkg::SRC_COLS-1:0]            match,
    output rbra_pkg::lane_res_t                      res
);
    import rbra_pkg::*;

    always_comb begin
        for (int c = 0; c < SRC_COLS; c++) begin
            match[c] = slot_valid[c] && (slot_banks[2*c +: 2] == bank_select);
        end
    end

    // Grant is one-hot across the whole block, so OR the selected columns.
    always_comb begin
        res.hit  = |grant;
        res.col  = '0;
        res.addr = '0;
        for (int c = 0; c < SRC_COLS; c++) begin
            if (grant[c]) begin
                res.col  = res.col | COL_W'(c);
                res.addr = res.addr | slot_addr[ADDR_W*c +: ADDR_W];
            end
        end
    end

endmodule

// ===== design/rbra_rr_pick.sv =====
// Round-robin merge of the lane match bits: first request at or after
// the start slot, wrapping once. Depends on rbra_pkg.
module rbra_rr_pick (
    input  logic [rbra_pkg::SLOT_COUNT-1:0] req,
    input  logic [rbra_pkg::PTR_W-1:0]      start,
    output logic [rbra_pkg::SLOT_COUNT-1:0] grant,
    output logic                            any
);
    import rbra_pkg::*;

    logic [SLOT_COUNT-1:0] upper_req;
    logic [SLOT_COUNT-1:0] sel_req;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            upper_req[i] = req[i] && (PTR_W'(i) >= start);
        end
    end

    // Isolate the lowest set bit of the chosen half.
    assign sel_req = (|upper_req) ? upper_req : req;
    assign grant   = sel_req & (~sel_req + SLOT_COUNT'(1));
    assign any     = |req;

endmodule

// ===== design/register_bank_read_arbiter.sv =====
// Top level of the register bank read arbiter: row lanes, round-robin merge,
// per-bank pointers and the output register. Depends on rbra_pkg,
// rbra_lane and rbra_rr_pick.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser bank, s_tdata slots
//  m_      | out | m_tvalid/m_tready  | m_tuser found, m_tdata grant and addr
//
// One transaction per clock while s_tready is high: the round is resolved in
// the cycle it is accepted and lands in the output register, with its bank
// pointer updated at the same edge when a slot wins, so the next round for
// that bank sees it at once. s_tready drops only while a result sits in the
// output register and m_tready is low. aresetn (synchronous) clears all
// bank pointers and the output valid.
module register_bank_read_arbiter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [131:84] slot_addr_high, [83:36] slot_addr_low, [35:12] slot_banks,
    // [11:0] slot_valid, [135:132] zero
    input  logic [rbra_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] bank_select
    input  logic [rbra_pkg::BANK_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [23:16] read_addr, [15:4] grant_onehot, [3:2] grant_col, [1:0] grant_row
    output logic [rbra_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] found
    output logic                            m_tuser
);
    import rbra_pkg::*;

    // Unpack the input transaction.
    logic [BANK_W-1:0]          bank_select;
    logic [SLOT_MAX-1:0]        slot_valid;
    logic [2*SLOT_MAX-1:0]      slot_banks;
    logic [ADDR_W*SLOT_MAX-1:0] slot_addr;   // slot s at [8s +: 8]

    assign bank_select = s_tuser;
    assign slot_valid  = s_tdata[11:0];
    assign slot_banks  = s_tdata[35:12];
    assign slot_addr   = {s_tdata[131:84], s_tdata[83:36]};

    // Output valid, declared here since the input handshake depends on it.
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;

    logic s_accept;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Bank pointers, one slot past the last winner of each bank.
    logic [PTR_W-1:0] bank_ptr_reg [BANK_PTR_DEPTH];
    logic [PTR_W-1:0] ptr_cur;
    logic [PTR_W-1:0] start;
    logic [PTR_W-1:0] ptr_next;
    logic             bank_ok;

    assign bank_ok = ({1'b0, bank_select} < (BANK_W+1)'(BANKS));
    assign ptr_cur = bank_ptr_reg[bank_select];
    assign start   = (ptr_cur >= PTR_W'(SLOT_COUNT)) ? ptr_cur - PTR_W'(SLOT_COUNT)
                                                     : ptr_cur;

    // Row lanes: each checks its three slots against the selected bank.
    logic [SLOT_COUNT-1:0] match;
    logic [SLOT_COUNT-1:0] req;
    logic [SLOT_COUNT-1:0] grant;
    logic                  any;
    lane_res_t             lane_res [COLLECTOR_ROWS];

    for (genvar r = 0; r < COLLECTOR_ROWS; r++) begin : g_lane
        rbra_lane u_lane (
            .slot_valid  (slot_valid[SRC_COLS*r +: SRC_COLS]),
            .slot_banks  (slot_banks[2*SRC_COLS*r +: 2*SRC_COLS]),
            .slot_addr   (slot_addr[ADDR_W*SRC_COLS*r +: ADDR_W*SRC_COLS]),
            .bank_select (bank_select),
            .grant       (grant[SRC_COLS*r +: SRC_COLS]),
            .match       (match[SRC_COLS*r +: SRC_COLS]),
            .res         (lane_res[r])
        );
    end

    // Drop every request when the bank is out of range.
    assign req = bank_ok ? match : '0;

    rbra_rr_pick u_pick (
        .req   (req),
        .start (start),
        .grant (grant),
        .any   (any)
    );

    // Merge the lane results; at most one lane reports a hit.
    logic [ROW_W-1:0]  grant_row;
    logic [COL_W-1:0]  grant_col;
    logic [ADDR_W-1:0] read_addr;

    always_comb begin
        grant_row = '0;
        grant_col = '0;
        read_addr = '0;
        for (int r = 0; r < COLLECTOR_ROWS; r++) begin
            if (lane_res[r].hit) begin
                grant_row = grant_row | ROW_W'(r);
            end
            grant_col = grant_col | lane_res[r].col;
            read_addr = read_addr | lane_res[r].addr;
        end
    end

    // Advance the pointer just past the winner.
    always_comb begin
        ptr_next = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (grant[i]) begin
                ptr_next = ptr_next | PTR_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < BANK_PTR_DEPTH; b++) begin
                bank_ptr_reg[b] <= '0;
            end
        end else if (s_accept && any) begin
            bank_ptr_reg[bank_select] <= ptr_next;
        end
    end

    // Output register.
    logic                  found_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the payload until the next accepted transaction.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            found_reg   <= any;
            m_tdata_reg <= {read_addr, SLOT_MAX'(grant), grant_col, grant_row};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = found_reg;

endmodule
